FILE: sv/strongly_connected_component_count_defines.svh
// Assertion macros for the component counter.
`ifndef STRONGLY_CONNECTED_COMPONENT_COUNT_DEFINES_SVH
`define STRONGLY_CONNECTED_COMPONENT_COUNT_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define SCC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/scc_pkg.sv
package scc_pkg;

  localparam int MaxVertices = 64;
  localparam int VtxW = $clog2(MaxVertices);
  localparam int CntW = VtxW + 1;

  typedef logic [VtxW-1:0] vtx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [MaxVertices-1:0] row_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_COUNT  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_F_SEED,
    ST_F_STEP,
    ST_F_POP,
    ST_R_PICK,
    ST_R_CHECK,
    ST_R_STEP,
    ST_R_POP,
    ST_OUT
  } state_t;

endpackage

FILE: sv/strongly_connected_component_count.sv
// Directed-graph strongly connected component counter (Kosaraju). The graph of up to 64
// vertices sits in two RAMs, the adjacency rows and their transpose. After reset the block
// zeroes both RAMs, one row per cycle, and is not ready until that is done. One transaction is
// in work at a time and s_axis_tready stays low until it is done and the previous result
// has left; tready may rise in the cycle the result is taken. An add or remove steps through
// a row read, a row write and the result; a clear zeroes every row, one row per cycle,
// before the result; a count seeds, pushes, searches and pops each of the N active
// vertices a bounded number of times, each step being one registered row read and one
// lowest-set-bit search. Edges with a vertex at or above vertex_count give status 1 and
// leave the graph alone; a vertex_count above 64 counts as 64.
`include "strongly_connected_component_count_defines.svh"
module strongly_connected_component_count (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [6:0] cfg_wdata,                  // vertex_count
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [15:0] s_axis_tdata,              // op[1:0], src_vertex[7:2], dst_vertex[13:8]
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [7:0] m_axis_tdata                // status[0], component_total[7:1]
);
  import scc_pkg::*;

  state_t state, state_next;
  logic [6:0] vertex_count;
  cnt_t n_act;

  row_t fwd_mem [MaxVertices];
  row_t rev_mem [MaxVertices];
  vtx_t fin_mem [MaxVertices];
  vtx_t stk_mem [MaxVertices];

  row_t fwd_q, rev_q, visited, assigned, live;
  vtx_t stk_q, fin_q;
  vtx_t top;
  cnt_t seed, depth, done, kidx;
  cnt_t total;
  op_t op;
  vtx_t src, dst;
  logic busy_out;
  logic booting;
  logic edge_ok;
  logic [7:0] out_data;

  // memory ports
  logic fwd_we, rev_we;
  vtx_t fwd_wa, rev_wa, fwd_ra, rev_ra;
  row_t fwd_wd, rev_wd;
  logic stk_we, fin_we;
  vtx_t stk_wa, stk_ra, fin_wa, fin_ra;
  vtx_t stk_wd, fin_wd;

  logic accept;
  vtx_t clr_idx;
  row_t next_mask;
  vtx_t low_idx;
  logic low_any;

  assign n_act = (vertex_count > cnt_t'(MaxVertices)) ? cnt_t'(MaxVertices)
                                                      : cnt_t'(vertex_count);
  assign edge_ok = (cnt_t'(src) < n_act) && (cnt_t'(dst) < n_act);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && !(m_axis_tvalid && !m_axis_tready);

  always_comb begin
    live = '0;
    for (int i = 0; i < MaxVertices; i++) begin
      live[i] = (cnt_t'(i) < n_act);
    end
  end

  // shared lowest-bit finder on the current row
  always_comb begin
    low_idx = '0;
    low_any = 1'b0;
    for (int i = MaxVertices - 1; i >= 0; i--) begin
      if (next_mask[i]) begin
        low_idx = vtx_t'(i);
        low_any = 1'b1;
      end
    end
  end

  always_comb begin
    next_mask = (state == ST_F_STEP) ? (fwd_q & live & ~visited)
                                     : (rev_q & live & ~assigned);
  end

  always_ff @(posedge clk) begin
    if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
    if (rev_we) rev_mem[rev_wa] <= rev_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (fin_we) fin_mem[fin_wa] <= fin_wd;
    fwd_q <= fwd_mem[fwd_ra];
    rev_q <= rev_mem[rev_ra];
    stk_q <= stk_mem[stk_ra];
    fin_q <= fin_mem[fin_ra];
  end

  always_comb begin
    state_next = state;
    fwd_we = 1'b0; rev_we = 1'b0; stk_we = 1'b0; fin_we = 1'b0;
    fwd_wa = src; rev_wa = dst; fwd_wd = fwd_q; rev_wd = rev_q;
    fwd_ra = top; rev_ra = top;
    stk_wa = vtx_t'(depth); stk_wd = low_idx;
    stk_ra = vtx_t'(depth - cnt_t'(1));
    fin_wa = vtx_t'(done); fin_wd = top;
    fin_ra = vtx_t'(kidx - cnt_t'(1));
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(s_axis_tdata[1:0])) inside
            OP_CLEAR: state_next = ST_CLEAR;
            OP_ADD, OP_REMOVE: state_next = ST_EDGE_RD;
            OP_COUNT: state_next = ST_F_SEED;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        fwd_we = 1'b1; rev_we = 1'b1; fwd_wa = clr_idx; rev_wa = clr_idx;
        fwd_wd = '0; rev_wd = '0;
        if (clr_idx == vtx_t'(MaxVertices - 1)) state_next = booting ? ST_IDLE : ST_OUT;
      end
      ST_EDGE_RD: begin
        fwd_ra = src; rev_ra = dst;
        state_next = ST_EDGE_WR;
      end
      ST_EDGE_WR: begin
        if (edge_ok) begin
          fwd_we = 1'b1; rev_we = 1'b1;
          fwd_wd[dst] = (op == OP_ADD);
          rev_wd[src] = (op == OP_ADD);
        end
        state_next = ST_OUT;
      end
      ST_F_SEED: begin
        if (seed >= n_act) begin
          state_next = ST_R_PICK;
        end else if (!visited[vtx_t'(seed)]) begin
          stk_we = 1'b1; stk_wa = '0; stk_wd = vtx_t'(seed);
          fwd_ra = vtx_t'(seed);
          state_next = ST_F_STEP;
        end
      end
      ST_F_STEP: begin
        if (low_any) begin
          stk_we = 1'b1;
          fwd_ra = low_idx;
        end else begin
          // finished: record it and fetch the entry below the top
          fin_we = 1'b1;
          stk_ra = vtx_t'(depth - cnt_t'(2));
          state_next = (depth == cnt_t'(1)) ? ST_F_SEED : ST_F_POP;
        end
      end
      ST_F_POP: begin
        fwd_ra = stk_q;
        state_next = ST_F_STEP;
      end
      ST_R_PICK: state_next = (kidx == '0) ? ST_OUT : ST_R_CHECK;
      ST_R_CHECK: begin
        if (assigned[fin_q]) begin
          state_next = ST_R_PICK;
        end else begin
          rev_ra = fin_q;
          state_next = ST_R_STEP;
        end
      end
      ST_R_STEP: begin
        if (low_any) begin
          stk_we = 1'b1;
        end else if (depth == '0) begin
          state_next = ST_R_PICK;
        end else begin
          state_next = ST_R_POP;
        end
      end
      ST_R_POP: begin
        rev_ra = stk_q;
        state_next = ST_R_STEP;
      end
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      vertex_count <= 7'd64;
      busy_out <= 1'b0;
      booting <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_we) vertex_count <= cfg_wdata;
      if (state == ST_OUT) busy_out <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) busy_out <= 1'b0;
      if (state == ST_CLEAR && clr_idx == vtx_t'(MaxVertices - 1)) booting <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_CLEAR;
      src <= '0;
      dst <= '0;
      clr_idx <= '0;
      visited <= '0;
      assigned <= '0;
      top <= '0;
      seed <= '0;
      depth <= '0;
      done <= '0;
      kidx <= '0;
      total <= '0;
      out_data <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op <= op_t'(s_axis_tdata[1:0]);
            src <= s_axis_tdata[7:2];
            dst <= s_axis_tdata[13:8];
            clr_idx <= '0;
            visited <= '0; assigned <= '0; done <= '0; total <= '0;
            seed <= '0; depth <= '0;
          end
        end
        ST_CLEAR: clr_idx <= clr_idx + vtx_t'(1);
        ST_F_SEED: begin
          if (seed >= n_act) begin
            kidx <= done;
          end else begin
            if (!visited[vtx_t'(seed)]) begin
              visited[vtx_t'(seed)] <= 1'b1;
              top <= vtx_t'(seed);
              depth <= cnt_t'(1);
            end
            seed <= seed + cnt_t'(1);
          end
        end
        ST_F_STEP: begin
          if (low_any) begin
            visited[low_idx] <= 1'b1;
            top <= low_idx;
            depth <= depth + cnt_t'(1);
          end else begin
            done <= done + cnt_t'(1);
            depth <= depth - cnt_t'(1);
          end
        end
        ST_F_POP: top <= stk_q;
        ST_R_PICK: begin
          if (kidx != '0) kidx <= kidx - cnt_t'(1);
        end
        ST_R_CHECK: begin
          // new root in reverse finishing order opens a component
          if (!assigned[fin_q]) begin
            assigned[fin_q] <= 1'b1;
            total <= total + cnt_t'(1);
            top <= fin_q;
            depth <= '0;
          end
        end
        ST_R_STEP: begin
          if (low_any) begin
            assigned[low_idx] <= 1'b1;
            depth <= depth + cnt_t'(1);
          end else if (depth != '0) begin
            depth <= depth - cnt_t'(1);
          end
        end
        ST_R_POP: top <= stk_q;
        ST_OUT: begin
          out_data <= {(op == OP_COUNT) ? total : cnt_t'(0),
                       (op == OP_ADD || op == OP_REMOVE) && !edge_ok};
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = busy_out;
  assign m_axis_tdata = out_data;

  `SCC_ASSERT_IMP(a_no_accept_busy, state != ST_IDLE, !s_axis_tready, "ready while busy")
  `SCC_ASSERT_NEXT(a_out_valid, state == ST_OUT, m_axis_tvalid, "result not posted")
  `SCC_ASSERT_IMP(a_depth_range, 1'b1, depth <= cnt_t'(MaxVertices), "stack overflow")
  `SCC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule
